[src/ba_pkg.sv]
// Shared types, constants and helpers of the buddy allocator.
package ba_pkg;

	localparam int HEAP_ORDER_DEF   = 16;
	localparam int MIN_ORDER_DEF    = 6;
	localparam int HEADER_BYTES_DEF = 32;
	localparam int MAX_HEAP_ORDER   = 26;
	localparam int MIN_SLACK        = 4;

	localparam int REQ_W   = 32;
	localparam int OFF_W   = 16;
	localparam int BYTES_W = 17;
	localparam int ORD_W   = 5;          // holds any order up to MAX_HEAP_ORDER
	localparam int SIZE_W  = REQ_W + 1;  // request plus header
	localparam int SORD_W  = 6;          // order of a SIZE_W value, up to SIZE_W

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_ALLOC_FAIL   = 2'd1,
		ST_FREE_IGNORED = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [REQ_W-1:0]   size_bytes;
		logic [OFF_W-1:0]   free_offset;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic [OFF_W-1:0]   payload_offset;
		logic [BYTES_W-1:0] granted_bytes;
		logic [BYTES_W-1:0] inuse_bytes;
		logic [BYTES_W-1:0] peak_bytes;
	} result_t;

	// Smallest o with 2^o >= v; used on constants at elaboration.
	function automatic int ceil_log2(input longint v);
		int o;
		o = 0;
		for (int i = 0; i < 63; i++) begin
			if ((64'd1 << i) < v) begin
				o = i + 1;
			end
		end
		return o;
	endfunction

endpackage

[src/ba_size_order.sv]
// Block order needed for a request size: smallest o with 2^o >= size.
module ba_size_order (
	input  logic [ba_pkg::SIZE_W-1:0] size,
	output logic [ba_pkg::SORD_W-1:0] order
);
	import ba_pkg::*;

	// Each compare is independent; the highest threshold passed sets the order.
	always_comb begin
		order = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if ((SIZE_W + 1)'(size) > ((SIZE_W + 1)'(1) << i)) begin
				order = SORD_W'(i + 1);
			end
		end
	end

endmodule

[src/buddy_allocator_top.sv]
// Binary buddy allocator: free-bit tree and per-unit order table in block memories.
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+---------------------------------------------
//  command  | start, cmd (cmd_t)       | word taken at an edge with start=1, busy=0
//  result   | done, result (result_t)  | done marks the word for one cycle, no stall
//
//  A free merges buddies up the tree; an allocate scans tree words up the orders,
//  then splits down; requests that fail at decode end in the decode state. The
//  read/modify/write of the free-bit memory (read in one state, written in the
//  next) paces both walks. After reset a clearing pass over all the
//  2^(HEAP_ORDER-MIN_ORDER) order-table entries (1024 by default) zeroes them and
//  plants the root, with busy high. The receiver cannot stall: each result shows for exactly one cycle.
module buddy_allocator_top #(
	parameter int HEAP_ORDER   = ba_pkg::HEAP_ORDER_DEF,
	parameter int MIN_ORDER    = ba_pkg::MIN_ORDER_DEF,
	parameter int HEADER_BYTES = ba_pkg::HEADER_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ba_pkg::cmd_t    cmd,
	output logic            busy,
	output logic            done,
	output ba_pkg::result_t result
);
	import ba_pkg::*;

	// Tree geometry: node n lives at level floor(log2 n); root is node 1.
	localparam int LEVELS = HEAP_ORDER - MIN_ORDER + 1;
	localparam int NW     = (LEVELS < 2) ? 2 : LEVELS;   // node index width
	localparam int WB     = (NW > 5) ? 5 : NW - 1;       // bit-in-word width
	localparam int WW     = 1 << WB;                     // free bits per word
	localparam int WAW    = NW - WB;                     // word address width
	localparam int WORDS  = 1 << WAW;
	localparam int UB     = HEAP_ORDER - MIN_ORDER;
	localparam int UAW    = (UB < 1) ? 1 : UB;           // unit address width
	localparam int UNITS  = 1 << UAW;
	localparam int AW     = HEAP_ORDER + 1;              // heap address plus one
	localparam int TW     = HEAP_ORDER + 1;              // byte totals
	localparam int SLACK_ORDER = ceil_log2(longint'(HEADER_BYTES + MIN_SLACK));
	localparam int OMIN   = (SLACK_ORDER > MIN_ORDER) ? SLACK_ORDER : MIN_ORDER;

	typedef enum logic [10:0] {
		S_CLEAR    = 11'b000_0000_0001,
		S_IDLE     = 11'b000_0000_0010,
		S_DEC      = 11'b000_0000_0100,
		S_ASCAN    = 11'b000_0000_1000,
		S_ACHK     = 11'b000_0001_0000,
		S_SPLIT_RD = 11'b000_0010_0000,
		S_SPLIT_WR = 11'b000_0100_0000,
		S_AFIN     = 11'b000_1000_0000,
		S_FCHK     = 11'b001_0000_0000,
		S_MRD      = 11'b010_0000_0000,
		S_MWR      = 11'b100_0000_0000
	} state_t;

	state_t              state_q;
	opcode_t             op_q;
	logic [SIZE_W-1:0]   size_q;
	logic                zero_q;
	logic [OFF_W-1:0]    off_q;
	logic [ORD_W-1:0]    order_q;
	logic [ORD_W-1:0]    k_q;
	logic [WAW-1:0]      word_q;
	logic [NW-1:0]       node_q;
	logic [UAW-1:0]      clr_q;
	logic [TW-1:0]       inuse_q;
	logic [TW-1:0]       peak_q;
	result_t             res_q;
	logic                done_q;

	// Free-bit tree, WW nodes to a word.
	logic [WW-1:0]       tree_mem [WORDS];
	logic [WW-1:0]       tree_rd_q;
	logic [WAW-1:0]      tree_ra;
	logic [WAW-1:0]      tree_wa;
	logic [WW-1:0]       tree_wd;
	logic                tree_we;

	// Order of the live block starting at each minimum-size unit; zero if none.
	logic [ORD_W-1:0]    unit_mem [UNITS];
	logic [ORD_W-1:0]    unit_rd_q;
	logic [UAW-1:0]      unit_ra;
	logic [UAW-1:0]      unit_wa;
	logic [ORD_W-1:0]    unit_wd;
	logic                unit_we;

	logic [SORD_W-1:0]   raw_ord;
	logic [SORD_W-1:0]   eff_ord;
	logic                alloc_bad;
	logic [ORD_W-1:0]    lvl0;
	logic [WAW-1:0]      first0;
	logic [OFF_W-1:0]    blk;
	logic                free_bad;
	logic [ORD_W-1:0]    lvl;
	logic [WW-1:0]       lvl_mask;
	logic [WW-1:0]       hit;
	logic                hit_any;
	logic [WB-1:0]       hit_bit;
	logic [WAW-1:0]      last_word;
	logic [WAW-1:0]      first_up;
	logic [NW-1:0]       child;
	logic [WB-1:0]       node_bit;
	logic                merge;
	logic [AW-1:0]       addr_full;
	logic [OFF_W-1:0]    alloc_pay;
	logic [TW-1:0]       gb;
	logic [TW-1:0]       inuse_add;
	logic [TW-1:0]       inuse_sub;
	logic [NW-1:0]       node_f;
	logic                unit_ok;

	ba_size_order u_size_order (
		.size  (size_q),
		.order (raw_ord)
	);

	function automatic result_t make_res(
		input status_t        st,
		input logic [OFF_W-1:0] pay,
		input logic [TW-1:0]  bytes,
		input logic [TW-1:0]  inuse,
		input logic [TW-1:0]  peak
	);
		result_t r;
		r.status         = st;
		r.payload_offset = pay;
		r.granted_bytes  = BYTES_W'(bytes);
		r.inuse_bytes    = BYTES_W'(inuse);
		r.peak_bytes     = BYTES_W'(peak);
		return r;
	endfunction

	// Allocate decode: clamp the order to the floor set by header, slack and MIN_ORDER.
	assign eff_ord   = (raw_ord < SORD_W'(OMIN)) ? SORD_W'(OMIN) : raw_ord;
	assign alloc_bad = zero_q || (eff_ord > SORD_W'(HEAP_ORDER));
	assign lvl0      = ORD_W'(HEAP_ORDER) - ORD_W'(eff_ord);
	assign first0    = WAW'((NW'(1) << lvl0) >> WB);

	// Free decode: below header, misaligned, or past the heap end is ignored.
	assign blk      = off_q - OFF_W'(HEADER_BYTES);
	assign free_bad = (off_q < OFF_W'(HEADER_BYTES)) ||
		((blk & OFF_W'((1 << MIN_ORDER) - 1)) != '0) ||
		((64'(blk) >> HEAP_ORDER) != 64'd0);

	// Scan of one tree word: keep only nodes of the current level, take the lowest.
	assign lvl = ORD_W'(HEAP_ORDER) - k_q;

	always_comb begin
		for (int b = 0; b < WW; b++) begin
			lvl_mask[b] = (({word_q, WB'(b)} >> lvl) == NW'(1));
		end
	end

	assign hit     = tree_rd_q & lvl_mask;
	assign hit_any = |hit;

	always_comb begin
		hit_bit = '0;
		for (int b = WW - 1; b >= 0; b--) begin
			if (hit[b]) begin
				hit_bit = WB'(b);
			end
		end
	end

	assign last_word = WAW'(((NW'(1) << (lvl + ORD_W'(1))) - NW'(1)) >> WB);
	assign first_up  = WAW'((NW'(1) << (lvl - ORD_W'(1))) >> WB);

	// Split and merge helpers.
	assign child    = {node_q[NW-2:0], 1'b1};
	assign node_bit = node_q[WB-1:0];
	assign merge    = (node_q > NW'(1)) && tree_rd_q[node_bit ^ WB'(1)];

	// Block address of a node: node << order, dropping the level marker bit.
	assign addr_full = AW'(node_q) << k_q;
	assign alloc_pay = OFF_W'(AW'(addr_full[AW-2:0]) + AW'(HEADER_BYTES));

	assign gb        = (TW'(1) << order_q) - TW'(HEADER_BYTES);
	assign inuse_add = inuse_q + gb;
	assign inuse_sub = (inuse_q >= gb) ? (inuse_q - gb) : '0;

	assign node_f  = NW'(((AW'(1) << HEAP_ORDER) | AW'(blk)) >> unit_rd_q);
	assign unit_ok = (unit_rd_q >= ORD_W'(MIN_ORDER)) && (unit_rd_q <= ORD_W'(HEAP_ORDER));

	// Memory port control. Every read-modify-write reads in one state and
	// writes in the next, so a read never races a write to the same word.
	always_comb begin
		tree_ra = word_q;
		tree_we = 1'b0;
		tree_wa = word_q;
		tree_wd = tree_rd_q;
		unit_ra = UAW'(blk >> MIN_ORDER);
		unit_we = 1'b0;
		unit_wa = UAW'(blk >> MIN_ORDER);
		unit_wd = '0;
		unique case (state_q)
			S_CLEAR: begin
				unit_we = 1'b1;
				unit_wa = clr_q;
				tree_we = ((clr_q >> WAW) == '0);
				tree_wa = WAW'(clr_q);
				tree_wd = (WAW'(clr_q) == '0) ? WW'(2) : '0;
			end
			S_ACHK: begin
				tree_we = hit_any;
				tree_wd = tree_rd_q & ~(WW'(1) << hit_bit);
			end
			S_SPLIT_RD: begin
				tree_ra = WAW'(child >> WB);
			end
			S_SPLIT_WR: begin
				tree_we = 1'b1;
				tree_wa = WAW'(child >> WB);
				tree_wd = tree_rd_q | (WW'(1) << child[WB-1:0]);
			end
			S_AFIN: begin
				unit_we = 1'b1;
				unit_wa = UAW'(addr_full[AW-2:0] >> MIN_ORDER);
				unit_wd = order_q;
			end
			S_FCHK: begin
				unit_we = unit_ok;
			end
			S_MRD: begin
				tree_ra = WAW'(node_q >> WB);
			end
			S_MWR: begin
				tree_we = 1'b1;
				tree_wa = WAW'(node_q >> WB);
				tree_wd = merge ? (tree_rd_q & ~(WW'(1) << (node_bit ^ WB'(1))))
					: (tree_rd_q | (WW'(1) << node_bit));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tree_we) begin
			tree_mem[tree_wa] <= tree_wd;
		end
		tree_rd_q <= tree_mem[tree_ra];
	end

	always_ff @(posedge clk) begin
		if (unit_we) begin
			unit_mem[unit_wa] <= unit_wd;
		end
		unit_rd_q <= unit_mem[unit_ra];
	end

	// Sequencer: decode, scan up through orders, split down, or merge up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			inuse_q <= '0;
			peak_q  <= '0;
			res_q   <= '0;
			op_q    <= OP_ALLOC;
			size_q  <= '0;
			zero_q  <= 1'b0;
			off_q   <= '0;
			order_q <= '0;
			k_q     <= '0;
			word_q  <= '0;
			node_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + UAW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= cmd.opcode;
						size_q  <= SIZE_W'(cmd.size_bytes) + SIZE_W'(HEADER_BYTES);
						zero_q  <= (cmd.size_bytes == '0);
						off_q   <= cmd.free_offset;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (op_q == OP_ALLOC) begin
						if (alloc_bad) begin
							res_q   <= make_res(ST_ALLOC_FAIL, '0, '0, inuse_q, peak_q);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							order_q <= ORD_W'(eff_ord);
							k_q     <= ORD_W'(eff_ord);
							word_q  <= first0;
							state_q <= S_ASCAN;
						end
					end else if (free_bad) begin
						res_q   <= make_res(ST_FREE_IGNORED, '0, '0, inuse_q, peak_q);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_FCHK;
					end
				end
				S_ASCAN: begin
					state_q <= S_ACHK;
				end
				S_ACHK: begin
					if (hit_any) begin
						node_q  <= {word_q, hit_bit};
						state_q <= (k_q == order_q) ? S_AFIN : S_SPLIT_RD;
					end else if (word_q == last_word) begin
						if (k_q == ORD_W'(HEAP_ORDER)) begin
							res_q   <= make_res(ST_ALLOC_FAIL, '0, '0, inuse_q, peak_q);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + ORD_W'(1);
							word_q  <= first_up;
							state_q <= S_ASCAN;
						end
					end else begin
						word_q  <= word_q + WAW'(1);
						state_q <= S_ASCAN;
					end
				end
				S_SPLIT_RD: begin
					state_q <= S_SPLIT_WR;
				end
				S_SPLIT_WR: begin
					// upper half is now free; descend into the lower half
					node_q  <= {node_q[NW-2:0], 1'b0};
					k_q     <= k_q - ORD_W'(1);
					state_q <= ((k_q - ORD_W'(1)) == order_q) ? S_AFIN : S_SPLIT_RD;
				end
				S_AFIN: begin
					inuse_q <= inuse_add;
					if (inuse_add > peak_q) begin
						peak_q <= inuse_add;
					end
					res_q <= make_res(ST_OK, alloc_pay, gb, inuse_add,
						(inuse_add > peak_q) ? inuse_add : peak_q);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FCHK: begin
					if (unit_ok) begin
						order_q <= unit_rd_q;
						node_q  <= node_f;
						state_q <= S_MRD;
					end else begin
						res_q   <= make_res(ST_FREE_IGNORED, '0, '0, inuse_q, peak_q);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					if (merge) begin
						node_q  <= node_q >> 1;
						state_q <= S_MRD;
					end else begin
						inuse_q <= inuse_sub;
						res_q   <= make_res(ST_OK, off_q, gb, inuse_sub, peak_q);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

[src/ba_checker.sv]
// Port-level checks of the buddy allocator, bound to the top level.
module ba_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input ba_pkg::result_t result
);
	import ba_pkg::*;

	// an accepted word keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// a result is only emitted as the block goes idle after work
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside end of work");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// failed or ignored requests grant nothing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_OK) |->
			(result.payload_offset == '0) && (result.granted_bytes == '0))
		else $error("failed request reports a grant");

endmodule

bind buddy_allocator_top ba_checker u_ba_checker (.*);

[sim/tb_buddy_allocator_top.sv]
// Testbench for the buddy allocator: random alloc/free traffic checked against a behavioral heap.
`timescale 1ns / 100ps

module tb_buddy_allocator_top;
	import ba_pkg::*;

	localparam int HEAP_ORDER   = HEAP_ORDER_DEF;
	localparam int MIN_ORDER    = MIN_ORDER_DEF;
	localparam int HEADER_BYTES = HEADER_BYTES_DEF;
	localparam int LEVELS       = HEAP_ORDER - MIN_ORDER + 1;
	localparam int NODES        = 1 << LEVELS;
	localparam int UNITS        = 1 << (HEAP_ORDER - MIN_ORDER);
	localparam int CYCLE_LIMIT  = 900000;

	logic    clk;
	logic    arst_n;
	logic    start;
	cmd_t    cmd;
	logic    busy;
	logic    done;
	result_t result;

	buddy_allocator_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// Behavioral heap: free bit per tree node, order of the live block per unit.
	bit                 node_free [NODES];
	logic [ORD_W-1:0]   unit_order [UNITS];
	logic [BYTES_W-1:0] heap_inuse;
	logic [BYTES_W-1:0] heap_peak;

	cmd_t         pending_cmds [$];
	result_t      expected_results [$];
	logic [15:0]  live_offsets [$];
	int           error_count;
	int           cycle_count = 0;
	int           gap_left;
	bit           stimulus_done;

	initial begin
		clk = 1'b0;
	end
	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	function automatic int size_order(input logic [63:0] v);
		int o;
		o = 0;
		while (o < 63 && (64'd1 << o) < v) o++;
		return o;
	endfunction

	function automatic result_t predict_heap_step(input cmd_t c);
		result_t r;
		int o, k, lvl, n, first, floor_ord, unit;
		bit found;
		logic [63:0] blk, granted;
		r = '0;
		found = 1'b0;
		n = 0;
		if (c.opcode == OP_ALLOC) begin
			r.status = ST_ALLOC_FAIL;
			if (c.size_bytes != 0) begin
				o = size_order({32'd0, c.size_bytes} + HEADER_BYTES);
				floor_ord = size_order(HEADER_BYTES + MIN_SLACK);
				if (floor_ord > o) o = floor_ord;
				if (o < MIN_ORDER) o = MIN_ORDER;
				if (o <= HEAP_ORDER) begin
					for (k = o; k <= HEAP_ORDER && !found; k++) begin
						lvl = HEAP_ORDER - k;
						first = 1 << lvl;
						for (int i = first; i < 2 * first && !found; i++)
							if (node_free[i]) begin
								found = 1'b1;
								n = i;
							end
						if (found) break;
					end
					if (found) begin
						node_free[n] = 1'b0;
						while (k > o) begin
							node_free[2 * n + 1] = 1'b1;
							n = 2 * n;
							k--;
						end
						blk = 64'(n - (1 << (HEAP_ORDER - o))) << o;
						unit_order[blk >> MIN_ORDER] = ORD_W'(o);
						granted = (64'd1 << o) - HEADER_BYTES;
						heap_inuse = heap_inuse + BYTES_W'(granted);
						if (heap_inuse > heap_peak) heap_peak = heap_inuse;
						r.status = ST_OK;
						r.payload_offset = OFF_W'(blk + HEADER_BYTES);
						r.granted_bytes = BYTES_W'(granted);
					end
				end
			end
		end else begin
			r.status = ST_FREE_IGNORED;
			blk = 64'(c.free_offset) - HEADER_BYTES;
			if (c.free_offset >= HEADER_BYTES && (blk & ((64'd1 << MIN_ORDER) - 1)) == 0
					&& blk < (64'd1 << HEAP_ORDER)) begin
				unit = int'(blk >> MIN_ORDER);
				o = unit_order[unit];
				if (o >= MIN_ORDER && o <= HEAP_ORDER) begin
					unit_order[unit] = '0;
					n = (1 << (HEAP_ORDER - o)) + int'(blk >> o);
					while (n > 1 && node_free[n ^ 1]) begin
						node_free[n ^ 1] = 1'b0;
						n = n >> 1;
					end
					node_free[n] = 1'b1;
					granted = (64'd1 << o) - HEADER_BYTES;
					if (heap_inuse >= granted) heap_inuse = heap_inuse - BYTES_W'(granted);
					else heap_inuse = '0;
					r.status = ST_OK;
					r.payload_offset = c.free_offset;
					r.granted_bytes = BYTES_W'(granted);
				end
			end
		end
		r.inuse_bytes = heap_inuse;
		r.peak_bytes = heap_peak;
		return r;
	endfunction

	function automatic cmd_t make_alloc(input logic [31:0] bytes);
		cmd_t c;
		c = '0;
		c.opcode = OP_ALLOC;
		c.size_bytes = bytes;
		c.free_offset = 16'($urandom);
		return c;
	endfunction

	function automatic cmd_t make_free(input logic [15:0] off);
		cmd_t c;
		c = '0;
		c.opcode = OP_FREE;
		c.size_bytes = $urandom;
		c.free_offset = off;
		return c;
	endfunction

	// Mostly small requests so the heap fills and frees hit live blocks; a few big or wild ones.
	function automatic logic [31:0] random_size();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return $urandom_range(1, 200);
		if (pick < 85) return $urandom_range(1, 4000);
		if (pick < 95) return $urandom_range(1, 65536);
		return $urandom;
	endfunction

	initial begin
		logic [15:0] off;
		int idx;
		for (int i = 0; i < NODES; i++) node_free[i] = 1'b0;
		node_free[1] = 1'b1;
		for (int i = 0; i < UNITS; i++) unit_order[i] = '0;
		heap_inuse = '0;
		heap_peak = '0;
		error_count = 0;
		stimulus_done = 1'b0;

		// Directed: zero size, oversize, whole heap, exhaustion, bad frees, double free.
		pending_cmds.push_back(make_alloc(32'd0));
		pending_cmds.push_back(make_alloc(32'hFFFF_FFFF));
		pending_cmds.push_back(make_alloc(32'd65537));
		pending_cmds.push_back(make_alloc(32'd65504));
		pending_cmds.push_back(make_alloc(32'd1));
		pending_cmds.push_back(make_free(16'd32));
		pending_cmds.push_back(make_free(16'd32));
		pending_cmds.push_back(make_alloc(32'd1));
		pending_cmds.push_back(make_alloc(32'd32));
		pending_cmds.push_back(make_alloc(32'd33));
		pending_cmds.push_back(make_alloc(32'd30000));
		pending_cmds.push_back(make_alloc(32'd40000));
		pending_cmds.push_back(make_free(16'd0));
		pending_cmds.push_back(make_free(16'd31));
		pending_cmds.push_back(make_free(16'd33));
		pending_cmds.push_back(make_free(16'hFFFF));
		pending_cmds.push_back(make_free(16'd96));
		pending_cmds.push_back(make_free(16'd160));
		pending_cmds.push_back(make_free(16'd32));
		pending_cmds.push_back(make_free(16'd32800));
		pending_cmds.push_back(make_free(16'd32800));
		pending_cmds.push_back(make_free(16'd32));
		for (int i = 0; i < 400; i++) begin
			idx = $urandom_range(0, 99);
			if (idx < 50) begin
				pending_cmds.push_back(make_alloc(random_size()));
			end else if (idx < 85) begin
				// A free of some plausible offset: an aligned guess, or a pick from a list of random aligned offsets.
				off = 16'(($urandom_range(0, UNITS - 1) << MIN_ORDER) + HEADER_BYTES);
				if (live_offsets.size() > 0 && $urandom_range(0, 3) != 0)
					off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
				pending_cmds.push_back(make_free(off));
			end else begin
				pending_cmds.push_back(make_free(16'($urandom)));
			end
			if (idx < 50) live_offsets.push_back(16'(($urandom_range(0, 63) << 10) + 32));
		end
		stimulus_done = 1'b1;
	end

	// Driver: hold start until accepted, then send the next word at once or draw a gap before it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap_left <= 0;
		end else if (start && !busy) begin
			expected_results.push_back(predict_heap_step(cmd));
			if (pending_cmds.size() > 0 && $urandom_range(0, 3) == 0) begin
				cmd <= pending_cmds.pop_front();
			end else begin
				start <= 1'b0;
				gap_left <= $urandom_range(0, 3);
			end
		end else if (!start) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_cmds.size() > 0) begin
				cmd <= pending_cmds.pop_front();
				start <= 1'b1;
			end
		end
	end

	// Monitor: compare each result word with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected word", 64'(result), 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", 64'(result.status), 64'(want.status));
				if (result.payload_offset !== want.payload_offset)
					report_mismatch("payload_offset", 64'(result.payload_offset),
						64'(want.payload_offset));
				if (result.granted_bytes !== want.granted_bytes)
					report_mismatch("granted_bytes", 64'(result.granted_bytes),
						64'(want.granted_bytes));
				if (result.inuse_bytes !== want.inuse_bytes)
					report_mismatch("inuse_bytes", 64'(result.inuse_bytes), 64'(want.inuse_bytes));
				if (result.peak_bytes !== want.peak_bytes)
					report_mismatch("peak_bytes", 64'(result.peak_bytes), 64'(want.peak_bytes));
			end
		end
	end

	// Watchdog: a run far past the slowest legal one is a hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout");
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b0;
		@(negedge clk);
		arst_n = 1'b1;
		wait (stimulus_done);
		@(posedge clk);
		while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
